[sv/jsa_pkg.sv]
// Package for the joystick scroll auto-repeat block: item and config types,
// kind codes, register indexes and reset values. No dependencies.
package jsa_pkg;

	localparam int unsigned IN_TDATA_W  = 56;
	localparam int unsigned OUT_TDATA_W = 8;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	// item kinds
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_TICK  = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_FIRST   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_NORMAL  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_STEP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_FLOOR   = 3'd4;

	// reset values (threshold is 0.45 in unsigned Q0.15)
	localparam logic [14:0] RST_AXIS_THRESHOLD = 15'd14746;
	localparam logic [15:0] RST_REPEAT_FIRST   = 16'd250;
	localparam logic [15:0] RST_REPEAT_NORMAL  = 16'd50;
	localparam logic [15:0] RST_REPEAT_STEP    = 16'd5;
	localparam logic [15:0] RST_REPEAT_FLOOR   = 16'd25;

	localparam logic [4:0] TAP_CODE = 5'd16;

	typedef struct packed {
		logic [1:0]         kind;
		logic [3:0]         source_id;
		logic               key_matches;
		logic signed [15:0] h_pos;
		logic signed [15:0] v_pos;
		logic               hard_press;
		logic [15:0]        elapsed_ms;
	} item_t;

	typedef struct packed {
		logic [14:0] axis_threshold;
		logic [15:0] repeat_first;
		logic [15:0] repeat_normal;
		logic [15:0] repeat_step;
		logic [15:0] repeat_floor;
	} cfg_t;

	typedef struct packed {
		logic claimed;
	} status_t;

endpackage

[sv/jsa_cfg.sv]
// Configuration register bank for the scroll auto-repeat block.
// Depends on jsa_pkg.
module jsa_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [jsa_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [jsa_pkg::CFG_DATA_W-1:0]  wr_data,
	output jsa_pkg::cfg_t                   cfg
);

	jsa_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.axis_threshold <= jsa_pkg::RST_AXIS_THRESHOLD;
			cfg_q.repeat_first   <= jsa_pkg::RST_REPEAT_FIRST;
			cfg_q.repeat_normal  <= jsa_pkg::RST_REPEAT_NORMAL;
			cfg_q.repeat_step    <= jsa_pkg::RST_REPEAT_STEP;
			cfg_q.repeat_floor   <= jsa_pkg::RST_REPEAT_FLOOR;
		end else if (wr_en) begin
			unique case (wr_index)
				jsa_pkg::REG_AXIS_THRESHOLD: cfg_q.axis_threshold <= wr_data[14:0];
				jsa_pkg::REG_REPEAT_FIRST:   cfg_q.repeat_first   <= wr_data;
				jsa_pkg::REG_REPEAT_NORMAL:  cfg_q.repeat_normal  <= wr_data;
				jsa_pkg::REG_REPEAT_STEP:    cfg_q.repeat_step    <= wr_data;
				jsa_pkg::REG_REPEAT_FLOOR:   cfg_q.repeat_floor   <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/jsa_core.sv]
// Claim/scroll/repeat state and the combinational decision logic for one item.
// Depends on jsa_pkg.
module jsa_core (
	input  logic             clk,
	input  logic             arst_n,
	input  jsa_pkg::item_t   item,
	input  logic             fire,
	input  jsa_pkg::cfg_t    cfg,
	output logic             res_valid,
	output logic [4:0]       res_code,
	output jsa_pkg::status_t status
);

	logic        claimed_q, claimed_n;
	logic [3:0]  owner_q, owner_n;
	logic        scrolled_q, scrolled_n;
	logic        hard_q, hard_n;
	logic [15:0] ttr_q, ttr_n;
	logic [15:0] intv_q, intv_n;

	logic signed [16:0] thr_pos, thr_neg, h_ext, v_ext;
	logic [3:0]         dir;
	logic [15:0]        intv_shrunk;

	assign thr_pos = $signed({2'b00, cfg.axis_threshold});
	assign thr_neg = -thr_pos;
	assign h_ext   = {item.h_pos[15], item.h_pos};
	assign v_ext   = {item.v_pos[15], item.v_pos};

	assign dir[0] = h_ext > thr_pos;
	assign dir[1] = !(h_ext > thr_pos) && (h_ext < thr_neg);
	assign dir[2] = v_ext > thr_pos;
	assign dir[3] = !(v_ext > thr_pos) && (v_ext < thr_neg);

	// acceleration: first -> normal, then down by step (saturating at 0); no change once at or below floor
	always_comb begin
		intv_shrunk = intv_q;
		if (intv_q > cfg.repeat_floor) begin
			if (intv_q == cfg.repeat_first)
				intv_shrunk = cfg.repeat_normal;
			else if (intv_q > cfg.repeat_step)
				intv_shrunk = intv_q - cfg.repeat_step;
			else
				intv_shrunk = '0;
		end
	end

	always_comb begin
		claimed_n  = claimed_q;
		owner_n    = owner_q;
		scrolled_n = scrolled_q;
		hard_n     = hard_q;
		ttr_n      = ttr_q;
		intv_n     = intv_q;
		res_valid  = 1'b0;
		res_code   = '0;
		case (item.kind)
			jsa_pkg::KIND_START: begin
				if (!claimed_q && item.key_matches) begin
					claimed_n  = 1'b1;
					owner_n    = item.source_id;
					scrolled_n = 1'b0;
					hard_n     = 1'b0;
					ttr_n      = '0;
					intv_n     = cfg.repeat_first;
				end
			end
			jsa_pkg::KIND_END: begin
				if (claimed_q && item.source_id == owner_q) begin
					claimed_n = 1'b0;
					if (!scrolled_q && hard_q) begin
						res_valid = 1'b1;
						res_code  = jsa_pkg::TAP_CODE;
					end
				end
			end
			jsa_pkg::KIND_TICK: begin
				if (claimed_q) begin
					if (item.hard_press)
						hard_n = 1'b1;
					if (dir == 4'd0) begin
						ttr_n  = '0;
						intv_n = cfg.repeat_first;
					end else begin
						scrolled_n = 1'b1;
						if (ttr_q == 16'd0) begin
							ttr_n     = intv_q;
							res_valid = 1'b1;
							res_code  = {1'b0, dir};
						end else if (ttr_q <= item.elapsed_ms) begin
							intv_n    = intv_shrunk;
							ttr_n     = intv_shrunk;
							res_valid = 1'b1;
							res_code  = {1'b0, dir};
						end else begin
							ttr_n = ttr_q - item.elapsed_ms;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			claimed_q  <= 1'b0;
			owner_q    <= '0;
			scrolled_q <= 1'b0;
			hard_q     <= 1'b0;
			ttr_q      <= '0;
			intv_q     <= jsa_pkg::RST_REPEAT_FIRST;
		end else if (fire) begin
			claimed_q  <= claimed_n;
			owner_q    <= owner_n;
			scrolled_q <= scrolled_n;
			hard_q     <= hard_n;
			ttr_q      <= ttr_n;
			intv_q     <= intv_n;
		end
	end

	assign status.claimed = claimed_q;

endmodule

[sv/joystick_scroll_autorepeat.sv]
// Joystick scroll auto-repeat: top level. Uses jsa_pkg, jsa_cfg, jsa_core.
// An item passes the input register, then the result register, on its way
// to m_axis. Throughput: one item per cycle while the output register has
// room for any result; the state update in jsa_core is combinational.
// Reset (arst_n low, async): block free, no items held, registers at defaults.
module joystick_scroll_autorepeat (
	input  logic                                clk,
	input  logic                                arst_n,
	// input item stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [3:0] source_id, [4] key_matches, [20:5] h_pos, [36:21] v_pos,
	// [37] hard_press, [53:38] elapsed_ms, [55:54] zero
	input  logic [jsa_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// [1:0] kind
	input  logic [1:0]                          s_axis_tuser,
	// result stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [4:0] event_code, [7:5] zero
	output logic [jsa_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [jsa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [jsa_pkg::CFG_DATA_W-1:0]      cfg_data
);

	jsa_pkg::cfg_t    cfg;
	jsa_pkg::status_t status;
	jsa_pkg::item_t   item_in, item_s1;
	logic             valid_s1;
	logic             fire;
	logic             res_valid;
	logic [4:0]       res_code;
	logic             out_valid_q;
	logic [4:0]       out_code_q;
	logic             out_free;

	// registers always take writes at once
	assign cfg_ready = 1'b1;

	jsa_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// unpack the incoming item
	assign item_in.kind        = s_axis_tuser;
	assign item_in.source_id   = s_axis_tdata[3:0];
	assign item_in.key_matches = s_axis_tdata[4];
	assign item_in.h_pos       = $signed(s_axis_tdata[20:5]);
	assign item_in.v_pos       = $signed(s_axis_tdata[36:21]);
	assign item_in.hard_press  = s_axis_tdata[37];
	assign item_in.elapsed_ms  = s_axis_tdata[53:38];

	// Stage 1 retires when its result (if any) has room in the output register.
	// Items that give no result never wait on the output side.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && (!res_valid || out_free);
	assign s_axis_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			item_s1 <= item_in;
	end

	jsa_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_s1),
		.fire      (fire),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res_code  (res_code),
		.status    (status)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= fire && res_valid;
	end

	always_ff @(posedge clk) begin
		if (out_free && fire && res_valid)
			out_code_q <= res_code;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_code_q};

	// a result is either a tap or a nonzero direction set
	a_code_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_code_q == jsa_pkg::TAP_CODE) ||
		(out_code_q != 5'd0 && !out_code_q[4]))
		else $error("illegal event code");

	// a tick never produces a result while the block is unclaimed
	a_tick_free: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && item_s1.kind == jsa_pkg::KIND_TICK && !status.claimed |-> !res_valid)
		else $error("result from tick while unclaimed");

	// a stalled result is not overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(out_code_q))
		else $error("stalled result lost");

	// a pending result blocks retirement of another result-producing item
	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_valid |-> !out_valid_q || m_axis_tready)
		else $error("result retired into a full output register");

endmodule
